/* rtl/rkc_pkg.sv */
package rkc_pkg;

  typedef enum logic [1:0] {
    OP_ACQ   = 2'd0,
    OP_REL   = 2'd1,
    OP_AGE   = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_USED = 2'd1,
    SL_DUMP = 2'd2,
    SL_MARK = 2'd3
  } slot_st_e;

  typedef enum logic [3:0] {
    RS_HIT      = 4'd0,
    RS_REVIVED  = 4'd1,
    RS_CREATED  = 4'd2,
    RS_FULL     = 4'd3,
    RS_OVERFLOW = 4'd4,
    RS_HELD     = 4'd5,
    RS_TO_DUMP  = 4'd6,
    RS_FREED    = 4'd7,
    RS_DELETED  = 4'd8,
    RS_BAD      = 4'd9,
    RS_DONE     = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_DONE,
    BK_EVSCAN,
    BK_EVICT
  } bk_state_e;

  localparam logic [4:0] DUMP_LIMIT_RST = 5'd4;

  // One queued command as classified by the front end.
  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [3:0]  handle;
    logic        hvalid;
  } cmd_t;

endpackage

/* rtl/refcounted_key_cache_with_dump.sv */
// A result is registered by the back end once its item leaves the queue.
// Acquire and a plain release finish when popped; a release that overflows the
// dump also scans every slot for a victim, and age and flush sweep every slot.
// Up to two items wait in the queue; busy is high while it is full.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset is asynchronous and active low: all slots free, dump empty, dump_limit 4.
module refcounted_key_cache_with_dump import rkc_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32,
  parameter int REF_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [3:0]  handle_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        valid_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  status_o,
  output logic [15:0] refs_o,
  output logic        last_o
);

  // The front end decodes each item and holds it in a two-entry queue.
  // The back end owns the slot table, pops one item when it is idle, and
  // walks the slots one per cycle for aging, flushing and victim search.
  logic pop;
  logic head_valid;
  cmd_t head;

  rkc_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .busy_o      (busy_o),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // Every result, including each deletion, leaves through one output register.
  rkc_back #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS),
    .REF_BITS(REF_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .slot_o      (slot_o),
    .status_o    (status_o),
    .refs_o      (refs_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/rkc_front.sv */
module rkc_front import rkc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  logic [31:0] key_i,
  input  logic [3:0] handle_i,
  output logic       busy_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output cmd_t       head_o
);

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd;

  // Decode the kind and check that the handle names a real slot.
  always_comb begin
    cmd.key    = key_i;
    cmd.handle = handle_i;
    cmd.hvalid = (32'(handle_i) < ENTRIES);
    case (kind_i)
      2'd0:    cmd.op = OP_ACQ;
      2'd1:    cmd.op = OP_REL;
      2'd2:    cmd.op = OP_AGE;
      default: cmd.op = OP_FLUSH;
    endcase
  end

  assign busy_o       = (cnt_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

/* rtl/rkc_back.sv */
module rkc_back import rkc_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32,
  parameter int REF_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        head_valid_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        valid_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  status_o,
  output logic [15:0] refs_o,
  output logic        last_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  slot_st_e            st_q   [ENTRIES];
  slot_st_e            st_d   [ENTRIES];
  logic [KEY_BITS-1:0] key_q  [ENTRIES];
  logic [KEY_BITS-1:0] key_d  [ENTRIES];
  logic [REF_BITS-1:0] refs_q [ENTRIES];
  logic [REF_BITS-1:0] refs_d [ENTRIES];
  logic [IDX_W-1:0]    rank_q [ENTRIES];
  logic [IDX_W-1:0]    rank_d [ENTRIES];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [4:0]       limit_q;
  bk_state_e        state_q, state_d;
  logic             flush_q, flush_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             mfound_q, mfound_d, ofound_q, ofound_d;
  logic [IDX_W-1:0] midx_q, midx_d, mrank_q, mrank_d;
  logic [IDX_W-1:0] oidx_q, oidx_d, orank_q, orank_d;

  logic             r_valid_q, r_valid_d, r_last_q, r_last_d;
  logic [IDX_W-1:0] r_slot_q, r_slot_d;
  status_e          r_status_q, r_status_d;
  logic [REF_BITS-1:0] r_refs_q, r_refs_d;

  logic [KEY_BITS-1:0] hkey;
  logic [IDX_W-1:0]    hidx;
  logic                rel_ok, rel_to_dump, need_evict;

  assign hkey = KEY_BITS'(head_i.key);
  assign hidx = IDX_W'(head_i.handle);
  assign rel_ok = head_i.hvalid && (st_q[hidx] == SL_USED);
  assign rel_to_dump = rel_ok && (refs_q[hidx] <= REF_BITS'(1)) && (limit_q != 5'd0);
  assign need_evict = (32'(cnt_q) + 32'd1) > 32'(limit_q);

  function automatic logic in_dump(slot_st_e s);
    return (s == SL_DUMP) || (s == SL_MARK);
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (head_i.op == OP_AGE || head_i.op == OP_FLUSH) begin
            state_d = BK_SWEEP;
          end else if (head_i.op == OP_REL && rel_to_dump && need_evict) begin
            state_d = BK_EVSCAN;
          end
        end
      end
      BK_SWEEP: begin
        if (idx_q == LAST_IDX) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE:  state_d = BK_IDLE;
      BK_EVSCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = BK_EVICT;
        end
      end
      BK_EVICT: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Table updates and results.
  always_comb begin
    logic             unl;
    logic [IDX_W-1:0] u;
    logic             f_used, f_dump, f_free;
    logic [IDX_W-1:0] i_used, i_dump, i_free;
    unl = 1'b0;
    u = '0;
    f_used = 1'b0; f_dump = 1'b0; f_free = 1'b0;
    i_used = '0; i_dump = '0; i_free = '0;
    st_d = st_q; key_d = key_q; refs_d = refs_q; rank_d = rank_q;
    cnt_d = cnt_q;
    flush_d = flush_q;
    idx_d = idx_q;
    mfound_d = mfound_q; midx_d = midx_q; mrank_d = mrank_q;
    ofound_d = ofound_q; oidx_d = oidx_q; orank_d = orank_q;
    pop_o = 1'b0;
    r_valid_d = 1'b0; r_last_d = 1'b0;
    r_slot_d = '0; r_status_d = RS_HIT; r_refs_d = '0;

    for (int i = 0; i < ENTRIES; i++) begin
      if (!f_used && st_q[i] == SL_USED && key_q[i] == hkey) begin
        f_used = 1'b1; i_used = IDX_W'(i);
      end
      if (!f_dump && in_dump(st_q[i]) && key_q[i] == hkey) begin
        f_dump = 1'b1; i_dump = IDX_W'(i);
      end
      if (!f_free && st_q[i] == SL_FREE) begin
        f_free = 1'b1; i_free = IDX_W'(i);
      end
    end

    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_ACQ: begin
              r_valid_d = 1'b1;
              r_last_d  = 1'b1;
              if (f_used) begin
                r_slot_d = i_used;
                if (refs_q[i_used] == '1) begin
                  r_status_d = RS_OVERFLOW;
                  r_refs_d   = refs_q[i_used];
                end else begin
                  refs_d[i_used] = refs_q[i_used] + 1'b1;
                  r_status_d = RS_HIT;
                  r_refs_d   = refs_q[i_used] + 1'b1;
                end
              end else if (f_dump) begin
                unl = 1'b1; u = i_dump;
                st_d[i_dump]   = SL_USED;
                refs_d[i_dump] = REF_BITS'(1);
                r_slot_d   = i_dump;
                r_status_d = RS_REVIVED;
                r_refs_d   = REF_BITS'(1);
              end else if (f_free) begin
                st_d[i_free]   = SL_USED;
                key_d[i_free]  = hkey;
                refs_d[i_free] = REF_BITS'(1);
                r_slot_d   = i_free;
                r_status_d = RS_CREATED;
                r_refs_d   = REF_BITS'(1);
              end else begin
                r_status_d = RS_FULL;
              end
            end
            OP_REL: begin
              r_valid_d = 1'b1;
              r_last_d  = 1'b1;
              r_slot_d  = hidx;
              if (!rel_ok) begin
                r_status_d = RS_BAD;
              end else if (refs_q[hidx] > REF_BITS'(1)) begin
                refs_d[hidx] = refs_q[hidx] - 1'b1;
                r_status_d = RS_HELD;
                r_refs_d   = refs_q[hidx] - 1'b1;
              end else if (limit_q == 5'd0) begin
                refs_d[hidx] = '0;
                st_d[hidx]   = SL_FREE;
                r_status_d   = RS_FREED;
              end else begin
                // Park at the dump front; everything already there ages by one.
                for (int j = 0; j < ENTRIES; j++) begin
                  if (in_dump(st_q[j])) begin
                    rank_d[j] = rank_q[j] + 1'b1;
                  end
                end
                refs_d[hidx] = '0;
                st_d[hidx]   = SL_DUMP;
                rank_d[hidx] = '0;
                cnt_d        = cnt_q + 1'b1;
                r_status_d   = RS_TO_DUMP;
                r_last_d     = !need_evict;
                idx_d        = '0;
                mfound_d     = 1'b0;
                ofound_d     = 1'b0;
              end
            end
            default: begin
              flush_d = (head_i.op == OP_FLUSH);
              idx_d   = '0;
            end
          endcase
        end
      end
      BK_SWEEP: begin
        if (flush_q) begin
          if (st_q[idx_q] != SL_FREE) begin
            st_d[idx_q]   = SL_FREE;
            refs_d[idx_q] = '0;
            r_valid_d = 1'b1;
            r_slot_d  = idx_q;
            r_status_d = RS_DELETED;
          end
        end else if (st_q[idx_q] == SL_MARK) begin
          unl = 1'b1; u = idx_q;
          r_valid_d = 1'b1;
          r_slot_d  = idx_q;
          r_status_d = RS_DELETED;
        end else if (st_q[idx_q] == SL_DUMP) begin
          st_d[idx_q] = SL_MARK;
        end
        idx_d = idx_q + 1'b1;
      end
      BK_DONE: begin
        if (flush_q) begin
          cnt_d = '0;
        end
        r_valid_d  = 1'b1;
        r_last_d   = 1'b1;
        r_status_d = RS_DONE;
      end
      BK_EVSCAN: begin
        if (st_q[idx_q] == SL_MARK && (!mfound_q || rank_q[idx_q] < mrank_q)) begin
          mfound_d = 1'b1; midx_d = idx_q; mrank_d = rank_q[idx_q];
        end
        if (in_dump(st_q[idx_q]) && (!ofound_q || rank_q[idx_q] > orank_q)) begin
          ofound_d = 1'b1; oidx_d = idx_q; orank_d = rank_q[idx_q];
        end
        idx_d = idx_q + 1'b1;
      end
      BK_EVICT: begin
        unl = 1'b1;
        u   = mfound_q ? midx_q : oidx_q;
        r_valid_d  = 1'b1;
        r_last_d   = 1'b1;
        r_slot_d   = u;
        r_status_d = RS_DELETED;
      end
      default: ;
    endcase

    // Take one slot out of the dump and close the gap in the ranks.
    if (unl) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (IDX_W'(j) != u && in_dump(st_q[j]) && rank_q[j] > rank_q[u]) begin
          rank_d[j] = rank_q[j] - 1'b1;
        end
      end
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
      if (!(state_q == BK_IDLE && head_i.op == OP_ACQ)) begin
        st_d[u] = SL_FREE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    refs_q <= refs_d;
    rank_q <= rank_d;
    idx_q  <= idx_d;
    midx_q <= midx_d; mrank_q <= mrank_d;
    oidx_q <= oidx_d; orank_q <= orank_d;
    r_slot_q   <= r_slot_d;
    r_status_q <= r_status_d;
    r_refs_q   <= r_refs_d;
    r_last_q   <= r_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        st_q[i] <= SL_FREE;
      end
      cnt_q     <= '0;
      limit_q   <= DUMP_LIMIT_RST;
      state_q   <= BK_IDLE;
      flush_q   <= 1'b0;
      mfound_q  <= 1'b0;
      ofound_q  <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      state_q   <= state_d;
      flush_q   <= flush_d;
      mfound_q  <= mfound_d;
      ofound_q  <= ofound_d;
      r_valid_q <= r_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  assign valid_o  = r_valid_q;
  assign slot_o   = 4'(r_slot_q);
  assign status_o = r_status_q;
  assign refs_o   = 16'(r_refs_q);
  assign last_o   = r_last_q;

endmodule

/* rtl/rkc_checker.sv */
module rkc_checker import rkc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic [3:0]  slot_o,
  input logic [3:0]  status_o,
  input logic [15:0] refs_o,
  input logic        last_o
);

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == RS_DONE |-> last_o && slot_o == 4'd0 && refs_o == 16'd0)
    else $error("done result malformed");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == RS_FULL |-> last_o && slot_o == 4'd0 && refs_o == 16'd0)
    else $error("full result malformed");

  a_delete_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == RS_DELETED || status_o == RS_BAD || status_o == RS_FREED)
    |-> refs_o == 16'd0)
    else $error("deletion carries a count");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == RS_HIT || status_o == RS_REVIVED || status_o == RS_CREATED
    || status_o == RS_HELD || status_o == RS_BAD) |-> last_o)
    else $error("single result not marked last");

endmodule

bind refcounted_key_cache_with_dump rkc_checker u_chk (.*);
